// ----- rtl/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and constants of the printer packet receiver.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned CmdW   = 4;

  // Packet phases
  typedef enum logic [2:0] {
    PH_AWAIT = 3'd0,
    PH_CMD   = 3'd1,
    PH_COMP  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHK   = 3'd5,
    PH_ACK   = 3'd6
  } phase_e;

  // Command codes
  localparam logic [CmdW-1:0] CMD_NONE   = 4'h0;
  localparam logic [CmdW-1:0] CMD_INIT   = 4'h1;
  localparam logic [CmdW-1:0] CMD_PRINT  = 4'h2;
  localparam logic [CmdW-1:0] CMD_DATA   = 4'h4;
  localparam logic [CmdW-1:0] CMD_STATUS = 4'hF;

  // Sync pair and reply bytes
  localparam logic [ByteW-1:0] SYNC_0       = 8'h88;
  localparam logic [ByteW-1:0] SYNC_1       = 8'h33;
  localparam logic [ByteW-1:0] REPLY_IDLE   = 8'h00;
  localparam logic [ByteW-1:0] REPLY_ACK    = 8'h81;
  localparam logic [ByteW-1:0] STATUS_READY = 8'h00;
  localparam logic [ByteW-1:0] STATUS_PRINT = 8'h04;
  localparam logic [ByteW-1:0] STATUS_DATA  = 8'h08;
  localparam logic [ByteW-1:0] STRIPS_MAX   = 8'hFF;

endpackage

// ----- rtl/ppr_if.sv -----
// ----------------------------------------------------------------------------
// ppr_if
// Valid/ready channels of the printer packet receiver: received bytes in,
// reply beats out.
// ----------------------------------------------------------------------------
interface ppr_rx_if;
  logic                       valid;
  logic                       ready;
  logic [ppr_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ppr_tx_if;
  logic                       valid;
  logic                       ready;
  logic [ppr_pkg::ByteW-1:0]  reply_byte;
  logic                       irq;
  logic                       command_done;
  logic [ppr_pkg::CmdW-1:0]   done_command;
  logic [ppr_pkg::ByteW-1:0]  strips_held;

  modport source (output valid, output reply_byte, output irq, output command_done,
                  output done_command, output strips_held, input ready);
  modport sink   (input valid, input reply_byte, input irq, input command_done,
                  input done_command, input strips_held, output ready);
endinterface

// ----- rtl/printer_packet_receiver.sv -----
// ----------------------------------------------------------------------------
// printer_packet_receiver
// Serial-link packet receiver of a thermal printer peripheral.
// ----------------------------------------------------------------------------
// Each beat on rx_i is one byte shifted in by the console; each beat on tx_o
// is the byte shifted back plus the interrupt flag, a command-executed flag
// with its code, and the strip count. The receiver hunts for the sync pair
// 0x88 0x33, then walks command, compression, 16-bit little-endian length,
// data and 16-bit checksum (not checked), answering each with 0x00 and an
// interrupt. The first zero acknowledge byte gets 0x81; the second runs the
// command and returns the status. Nonzero acknowledge bytes raise no
// interrupt and change nothing. Rate: one byte per clock while tx_o takes
// each reply. A byte passes an input register, then the packet state update
// and the result register, from which its reply is offered on tx_o. rx_i.ready
// drops only while both registers hold beats and tx_o is stalled.
// ----------------------------------------------------------------------------
module printer_packet_receiver (
  input  logic     clk_i,
  input  logic     rst_ni,
  ppr_rx_if.sink   rx_i,
  ppr_tx_if.source tx_o
);
  import ppr_pkg::*;

  // Input stage
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             adv;      // input stage moves into result stage

  // Result stage
  logic             out_vld_q;
  logic [ByteW-1:0] reply_q, reply_d;
  logic             irq_q, irq_d;
  logic             done_q, done_d;
  logic [CmdW-1:0]  code_q, code_d;

  // Packet state
  phase_e            phase_q, phase_d;
  logic              win_vld_q, win_vld_d;
  logic [ByteW-1:0]  prev_q, prev_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]  status_q, status_d;
  logic [ByteW-1:0]  strips_q, strips_d;

  logic [CountW-1:0] cnt_inc;
  logic [CountW-1:0] len_full;
  logic              cmd_ok;
  logic [ByteW-1:0]  b;

  assign adv        = in_vld_q && (!out_vld_q || tx_o.ready);
  assign rx_i.ready = !in_vld_q || adv;
  assign b          = in_byte_q;
  assign cnt_inc    = cnt_q + CountW'(1);
  assign len_full   = {b, len_q[ByteW-1:0]};
  assign cmd_ok     = (b[CmdW-1:0] == CMD_INIT  || b[CmdW-1:0] == CMD_PRINT ||
                       b[CmdW-1:0] == CMD_DATA  || b[CmdW-1:0] == CMD_STATUS) &&
                      (b[ByteW-1:CmdW] == '0);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Packet state update for the byte in the input register
  always_comb begin
    phase_d   = phase_q;
    win_vld_d = win_vld_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    cmd_d     = cmd_q;
    status_d  = status_q;
    strips_d  = strips_q;
    reply_d   = REPLY_IDLE;
    irq_d     = 1'b1;
    done_d    = 1'b0;
    code_d    = CMD_NONE;

    unique case (phase_q)
      PH_CMD: begin
        if (cmd_ok) begin
          cmd_d   = b[CmdW-1:0];
          phase_d = PH_COMP;
        end else begin
          phase_d   = PH_AWAIT;
          win_vld_d = 1'b0;
        end
      end
      PH_COMP: begin
        cnt_d   = '0;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (cnt_q == '0) begin
          len_d = {{(CountW-ByteW){1'b0}}, b};
          cnt_d = CountW'(1);
        end else begin
          len_d   = len_full;
          cnt_d   = '0;
          phase_d = (len_full != '0) ? PH_DATA : PH_CHK;
        end
      end
      PH_DATA: begin
        if (cnt_inc == len_q) begin
          cnt_d   = '0;
          phase_d = PH_CHK;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_CHK: begin
        if (cnt_q == '0) begin
          cnt_d = CountW'(1);
        end else begin
          cnt_d   = '0;
          phase_d = PH_ACK;
        end
      end
      PH_ACK: begin
        priority if (b != '0) begin
          irq_d = 1'b0;
        end else if (cnt_q == '0) begin
          cnt_d   = CountW'(1);
          reply_d = REPLY_ACK;
        end else begin
          // Execute: second zero byte of the acknowledge
          reply_d = status_q;
          if (cmd_q == CMD_INIT) begin
            status_d = STATUS_READY;
            strips_d = '0;
            reply_d  = STATUS_READY;
          end else if (cmd_q == CMD_PRINT) begin
            status_d = STATUS_PRINT;
            strips_d = '0;
            reply_d  = STATUS_PRINT;
          end else if (cmd_q == CMD_DATA) begin
            status_d = STATUS_DATA;
            reply_d  = STATUS_DATA;
            if (strips_q != STRIPS_MAX) begin
              strips_d = strips_q + ByteW'(1);
            end
          end
          done_d    = 1'b1;
          code_d    = cmd_q;
          cnt_d     = '0;
          win_vld_d = 1'b0;
          phase_d   = PH_AWAIT;
        end
      end
      default: begin
        // Sync hunt; unused codes behave as awaiting packet
        if (win_vld_q && prev_q == SYNC_0 && b == SYNC_1) begin
          phase_d = PH_CMD;
          cnt_d   = '0;
        end else begin
          phase_d   = PH_AWAIT;
          prev_d    = b;
          win_vld_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_AWAIT;
      win_vld_q <= 1'b0;
      prev_q    <= '0;
      cnt_q     <= '0;
      len_q     <= '0;
      cmd_q     <= CMD_NONE;
      status_q  <= STATUS_READY;
      strips_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q   <= phase_d;
        win_vld_q <= win_vld_d;
        prev_q    <= prev_d;
        cnt_q     <= cnt_d;
        len_q     <= len_d;
        cmd_q     <= cmd_d;
        status_q  <= status_d;
        strips_q  <= strips_d;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      reply_q <= reply_d;
      irq_q   <= irq_d;
      done_q  <= done_d;
      code_q  <= code_d;
    end
  end

  assign tx_o.valid        = out_vld_q;
  assign tx_o.reply_byte   = reply_q;
  assign tx_o.irq          = irq_q;
  assign tx_o.command_done = done_q;
  assign tx_o.done_command = code_q;
  assign tx_o.strips_held  = strips_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_has_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && done_q |-> irq_q)
    else $error("executed command without interrupt");

  a_code_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !done_q |-> code_q == CMD_NONE)
    else $error("command code without execution");

  a_data_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && done_q && code_q == CMD_DATA |-> strips_q != '0)
    else $error("data command left strip count at zero");

  a_ack_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ACK || phase_q == PH_CHK |-> cnt_q[CountW-1:1] == '0)
    else $error("acknowledge/checksum counter out of range");

  a_exec_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && done_d |=> phase_q == PH_AWAIT && !win_vld_q)
    else $error("no return to sync hunt after execution");

endmodule
